@@ design/aie_pkg.sv @@
// shared types, widths and constants of the arithmetic interval encoder
package aie_pkg;

    localparam int SYM_W  = 8;
    localparam int PROB_W = 17;
    localparam int IVL_W  = 33;
    localparam int IDX_W  = 5;
    localparam int CFG_W  = 6;
    localparam int PROD_W = 34;
    localparam int OFF_W  = 35;

    localparam logic [PROB_W-1:0] ONE_Q16 = 17'h1_0000;
    localparam logic [IVL_W-1:0]  ONE_Q32 = 33'h1_0000_0000;
    localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = 6'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    typedef struct packed {
        logic [SYM_W-1:0]  code;
        logic [PROB_W-1:0] p_lo;
        logic [PROB_W-1:0] p_hi;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        t_entry           data;
    } t_tbl_wr;

    typedef struct packed {
        logic              start;
        logic [IVL_W-1:0]  range;
        logic [PROB_W-1:0] p_lo;
        logic [PROB_W-1:0] p_hi;
    } t_mac_req;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] off_hi;
        logic [OFF_W-1:0] off_lo;
    } t_mac_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_EMIT
    } t_state;

    function automatic logic [PROB_W-1:0] sat_q16(input logic [PROB_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

@@ design/aie_in_if.sv @@
// input word channel: load or encode item
interface aie_in_if;
    import aie_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [IDX_W-1:0]  entry_index;
    logic [SYM_W-1:0]  symbol;
    logic [PROB_W-1:0] prob_low;
    logic [PROB_W-1:0] prob_high;
    logic              last_symbol;

    modport source (
        output valid, func, entry_index, symbol, prob_low, prob_high, last_symbol,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, symbol, prob_low, prob_high, last_symbol,
        output ready
    );
endinterface

@@ design/aie_out_if.sv @@
// output word channel: encoded tag
interface aie_out_if;
    import aie_pkg::*;

    logic             valid;
    logic             ready;
    logic [IVL_W-1:0] tag;

    modport source (
        output valid, tag,
        input  ready
    );

    modport sink (
        input  valid, tag,
        output ready
    );
endinterface

@@ design/aie_table.sv @@
// symbol table memory, one write port and one registered read port
module aie_table #(
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  aie_pkg::t_tbl_wr i_wr,
    input  logic [AW-1:0]    i_rd_addr,
    output aie_pkg::t_entry  o_rd_data
);
    import aie_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;
    t_entry wr_entry;

    always_comb begin
        wr_entry      = i_wr.data;
        wr_entry.p_lo = sat_q16(i_wr.data.p_lo);
        wr_entry.p_hi = sat_q16(i_wr.data.p_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (32'(i_wr.index) < DEPTH)) begin
            r_mem[AW'(i_wr.index)] <= wr_entry;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/aie_mac.sv @@
// shared 17x17 multiplier that forms both scaled interval offsets in four passes
module aie_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aie_pkg::t_mac_req i_req,
    output aie_pkg::t_mac_rsp o_rsp
);
    import aie_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic [2:0]        acc_step;
    logic [IVL_W-1:0]  r_range;
    logic [PROB_W-1:0] r_plo;
    logic [PROB_W-1:0] r_phi;
    logic [PROD_W-1:0] r_prod;
    logic [OFF_W-1:0]  r_acc_hi;
    logic [OFF_W-1:0]  r_acc_lo;
    logic [PROB_W-1:0] mul_a;
    logic [PROB_W-1:0] mul_b;
    logic [OFF_W-1:0]  term;

    // step bit 0 picks the range half, bit 1 picks the bound
    always_comb begin
        mul_a    = r_step[0] ? {1'b0, r_range[15:0]} : r_range[IVL_W-1:16];
        mul_b    = r_step[1] ? r_plo : r_phi;
        acc_step = r_step - 3'd1;
        term     = acc_step[0] ? OFF_W'(r_prod[PROD_W-1:16]) : OFF_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_step   <= '0;
                r_range  <= i_req.range;
                r_plo    <= i_req.p_lo;
                r_phi    <= i_req.p_hi;
                r_acc_hi <= '0;
                r_acc_lo <= '0;
            end else if (r_busy) begin
                if (r_step != LAST_STEP) begin
                    r_prod <= mul_a * mul_b;
                end
                if (r_step != 3'd0) begin
                    if (acc_step[1]) begin
                        r_acc_lo <= r_acc_lo + term;
                    end else begin
                        r_acc_hi <= r_acc_hi + term;
                    end
                end
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.off_hi = r_acc_hi;
    assign o_rsp.off_lo = r_acc_lo;

endmodule

@@ design/arithmetic_interval_encoder_core.sv @@
// arithmetic interval encoder core: table scan, interval update and tag output
// a load word only writes the table; an encode word's time is set by a table scan of up to
// L = max(1, min(table_size, TABLE_DEPTH)) entries at one read per cycle and by
// four passes through the multiplier, plus any wait while an earlier tag is still held
// one word is worked on at a time; a new word is taken while a tag waits at the output
// synchronous active-low reset: interval [0, 1], table_size 1, table contents undefined
module arithmetic_interval_encoder_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    aie_in_if.sink                    i_in,
    aie_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [aie_pkg::CFG_W-1:0] i_cfg_wdata
);
    import aie_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CFG_W-1:0]  r_table_size;
    logic [IVL_W-1:0]  r_low;
    logic [IVL_W-1:0]  r_high;
    logic [IVL_W-1:0]  r_range;
    logic [SYM_W-1:0]  r_sym;
    logic              r_last;
    logic [CW-1:0]     r_limit;
    logic [CW-1:0]     r_addr;
    logic              r_pend;
    logic              r_first;
    logic              r_mac_go;
    t_entry            r_sel;
    logic              r_out_valid;
    logic [IVL_W-1:0]  r_tag;

    t_tbl_wr           tbl_wr;
    t_entry            rd_data;
    t_mac_req          mac_req;
    t_mac_rsp          mac_rsp;
    logic              in_ready;
    logic              in_acc;
    logic              hit;
    logic              issue;
    logic              out_free;
    logic              emit;
    int                limit_raw;
    logic [IVL_W:0]    tag_sum;

    aie_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    aie_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_rsp   (mac_rsp)
    );

    always_comb begin
        limit_raw = (32'(r_table_size) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(r_table_size);
        if (limit_raw == 0) begin
            limit_raw = 1;
        end
        hit      = (r_state == S_SCAN) && r_pend && (rd_data.code == r_sym);
        issue    = !hit && (r_addr != r_limit);
        out_free = !r_out_valid || o_out.ready;
        tag_sum  = {1'b0, r_low} + {1'b0, r_high};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.func == FUNC_ENCODE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || (r_addr == r_limit)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mac_rsp.done) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready           = 1'b0;
        emit               = 1'b0;
        unique case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_SCAN:  in_ready = 1'b0;
            S_MUL:   in_ready = 1'b0;
            S_EMIT:  emit     = out_free;
            default: in_ready = 1'b0;
        endcase
        in_acc             = i_in.valid && in_ready;
        tbl_wr.en          = in_acc && (i_in.func == FUNC_LOAD);
        tbl_wr.index       = i_in.entry_index;
        tbl_wr.data.code   = i_in.symbol;
        tbl_wr.data.p_lo   = i_in.prob_low;
        tbl_wr.data.p_hi   = i_in.prob_high;
        mac_req.start      = r_mac_go;
        mac_req.range      = r_range;
        mac_req.p_lo       = r_sel.p_lo;
        mac_req.p_hi       = r_sel.p_hi;
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.tag   = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= TABLE_SIZE_RST;
            r_low        <= '0;
            r_high       <= ONE_Q32;
            r_pend       <= 1'b0;
            r_first      <= 1'b0;
            r_mac_go     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_addr       <= '0;
        end else begin
            r_state  <= n_state;
            r_mac_go <= (r_state == S_SCAN) && !issue;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in.func == FUNC_ENCODE)) begin
                        r_sym   <= i_in.symbol;
                        r_last  <= i_in.last_symbol;
                        r_limit <= CW'(limit_raw);
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_range <= (r_high >= r_low) ? (r_high - r_low) : '0;
                    end
                end
                S_SCAN: begin
                    if (hit || (r_pend && r_first)) begin
                        r_sel <= rd_data;
                    end
                    r_pend  <= issue;
                    r_first <= (r_addr == '0);
                    if (issue) begin
                        r_addr <= r_addr + CW'(1);
                    end
                end
                S_MUL: begin
                    if (mac_rsp.done) begin
                        r_high <= IVL_W'({2'b00, r_low} + mac_rsp.off_hi);
                        r_low  <= IVL_W'({2'b00, r_low} + mac_rsp.off_lo);
                    end
                end
                S_EMIT: begin
                    if (emit) begin
                        r_tag       <= tag_sum[IVL_W:1];
                        r_low       <= '0;
                        r_high      <= ONE_Q32;
                    end
                end
                default: r_pend <= 1'b0;
            endcase
        end
    end

    a_interval_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_low == '0) && (r_high == ONE_Q32) && r_out_valid)
        else $error("interval not reset after tag");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_limit))
        else $error("table scan ran past limit");

    a_mac_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_rsp.done |-> (r_state == S_MUL))
        else $error("multiplier finished outside update phase");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !tbl_wr.en)
        else $error("table written during scan");

endmodule
